>>> rtl/core/stkw_pkg.sv
package stkw_pkg;

    localparam int POS_BITS     = 32;
    localparam int OUT_POS_BITS = 32;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW      = $clog2(FIFO_DEPTH + 1);

    typedef logic [POS_BITS-1:0]     t_pos;
    typedef logic [OUT_POS_BITS-1:0] t_out_pos;
    typedef logic [3:0]              t_kind;
    typedef logic [2:0]              t_len;
    typedef logic [FIFO_AW-1:0]      t_fptr;
    typedef logic [FIFO_CW-1:0]      t_fcnt;

    typedef enum logic [2:0] {
        MODE_NONE  = 3'd0,
        MODE_PLUS  = 3'd1,
        MODE_BANG  = 3'd2,
        MODE_NUM   = 3'd3,
        MODE_IDENT = 3'd4
    } t_mode;

    localparam t_kind K_EOF       = 4'd0;
    localparam t_kind K_NL        = 4'd1;
    localparam t_kind K_LBRACE    = 4'd2;
    localparam t_kind K_RBRACE    = 4'd3;
    localparam t_kind K_LPAR      = 4'd4;
    localparam t_kind K_RPAR      = 4'd5;
    localparam t_kind K_COLON     = 4'd6;
    localparam t_kind K_PLUS      = 4'd7;
    localparam t_kind K_PLUSPLUS  = 4'd8;
    localparam t_kind K_NEQ       = 4'd9;
    localparam t_kind K_EQ        = 4'd10;
    localparam t_kind K_NUM       = 4'd11;
    localparam t_kind K_IDENT     = 4'd12;
    localparam t_kind K_CLASS     = 4'd13;
    localparam t_kind K_VAL       = 4'd14;
    localparam t_kind K_ERR       = 4'd15;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam t_len CLASS_LEN = 3'd5;
    localparam t_len VAL_LEN   = 3'd3;
    localparam t_len LEN_MAX   = 3'd7;

    typedef struct packed {
        t_kind    kind;
        t_out_pos start_pos;
        t_out_pos end_pos;
        logic     last;
    } t_token;

    function automatic logic is_space(logic [7:0] c);
        return (c >= 8'h09 && c <= 8'h0D) || c == CH_SPACE;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_ident_start(logic [7:0] c);
        logic [7:0] l;
        l = c | 8'h20;
        return (l >= 8'h61 && l <= 8'h7A) || c == CH_UNDER;
    endfunction

    function automatic logic is_single(logic [7:0] c);
        return c == CH_NL || c == CH_LBRACE || c == CH_RBRACE || c == CH_LPAR
            || c == CH_RPAR || c == CH_COLON || c == CH_EQ;
    endfunction

    function automatic t_kind single_kind(logic [7:0] c);
        t_kind k;
        case (c)
            CH_NL:     k = K_NL;
            CH_LBRACE: k = K_LBRACE;
            CH_RBRACE: k = K_RBRACE;
            CH_LPAR:   k = K_LPAR;
            CH_RPAR:   k = K_RPAR;
            CH_COLON:  k = K_COLON;
            CH_EQ:     k = K_EQ;
            default:   k = K_ERR;
        endcase
        return k;
    endfunction

    // keyword letters by index
    function automatic logic [7:0] class_char(t_len idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h63;
            3'd1:    ch = 8'h6C;
            3'd2:    ch = 8'h61;
            3'd3:    ch = 8'h73;
            3'd4:    ch = 8'h73;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] val_char(t_len idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h76;
            3'd1:    ch = 8'h61;
            3'd2:    ch = 8'h6C;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic t_out_pos out_pos(t_pos p);
        logic [63:0] wide;
        wide = 64'(p);
        return wide[OUT_POS_BITS-1:0];
    endfunction

    function automatic t_token mk_tok(t_kind k, t_pos s, t_pos e);
        t_token t;
        t.kind      = k;
        t.start_pos = out_pos(s);
        t.end_pos   = out_pos(e);
        t.last      = 1'b0;
        return t;
    endfunction

    function automatic t_kind ident_kind(logic class_ok, logic val_ok, t_len len);
        t_kind k;
        if (class_ok && len == CLASS_LEN) begin
            k = K_CLASS;
        end else if (val_ok && len == VAL_LEN) begin
            k = K_VAL;
        end else begin
            k = K_IDENT;
        end
        return k;
    endfunction

endpackage

>>> rtl/core/source_tokenizer_with_keywords.sv
// flow: an accepted request is held in the input stage and is written to the token queue when it
//   is consumed; the queue head drives the output
// throughput: one source byte per cycle while the token queue holds at most two tokens; a byte
//   that yields two tokens leaves through the single output port draining the four-entry token queue
// reset: synchronous active low; clears the lexer state, the input stage and the queue
module source_tokenizer_with_keywords (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_byte
    input  logic        s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // start_pos, end_pos
    output logic [3:0]  m_axis_tuser,   // token_kind
    output logic        m_axis_tlast    // last_of_run
);

    logic       r_in_valid;
    logic       r_in_cmd;
    logic [7:0] r_in_char;

    stkw_pkg::t_mode r_mode, n_mode;
    stkw_pkg::t_pos  r_start, n_start;
    stkw_pkg::t_pos  r_pos, n_pos;
    logic            r_class_ok, n_class_ok;
    logic            r_val_ok, n_val_ok;
    stkw_pkg::t_len  r_len, n_len;
    logic            r_halted, n_halted;

    stkw_pkg::t_token r_fifo [stkw_pkg::FIFO_DEPTH];
    stkw_pkg::t_fptr  r_wr, r_rd;
    stkw_pkg::t_fcnt  r_count;

    logic             w_consume;
    logic             w_pop;
    logic             w_fresh;
    logic             w_space, w_digit, w_body, w_start_ch, w_single;
    stkw_pkg::t_pos   w_pos1;
    stkw_pkg::t_token w_res0, w_res1;
    logic [1:0]       w_nres;
    logic [1:0]       w_push;

    assign w_consume = r_in_valid && (r_count <= stkw_pkg::t_fcnt'(stkw_pkg::FIFO_DEPTH - 2));
    assign s_axis_tready = !r_in_valid || w_consume;
    assign w_pop = m_axis_tvalid && m_axis_tready;
    assign w_push = w_consume ? w_nres : 2'd0;

    assign w_space    = stkw_pkg::is_space(r_in_char);
    assign w_digit    = stkw_pkg::is_digit(r_in_char);
    assign w_body     = stkw_pkg::is_ident_start(r_in_char) || w_digit;
    assign w_single   = stkw_pkg::is_single(r_in_char);
    assign w_start_ch = r_in_char == stkw_pkg::CH_PLUS || r_in_char == stkw_pkg::CH_BANG
                     || w_body;
    assign w_pos1     = r_pos + stkw_pkg::t_pos'(1);

    // byte handled as fresh input after any pending token closes
    always_comb begin
        w_fresh = 1'b0;
        if (!r_halted && !r_in_cmd) begin
            case (r_mode)
                stkw_pkg::MODE_PLUS:  w_fresh = r_in_char != stkw_pkg::CH_PLUS;
                stkw_pkg::MODE_BANG:  w_fresh = 1'b0;
                stkw_pkg::MODE_NUM:   w_fresh = w_space;
                stkw_pkg::MODE_IDENT: w_fresh = !w_body;
                default:              w_fresh = 1'b1;
            endcase
        end
    end

    // next lexer state
    always_comb begin
        n_mode     = r_mode;
        n_start    = r_start;
        n_pos      = r_pos;
        n_class_ok = r_class_ok;
        n_val_ok   = r_val_ok;
        n_len      = r_len;
        n_halted   = r_halted;
        if (!r_halted) begin
            if (r_in_cmd) begin
                if (r_mode == stkw_pkg::MODE_BANG || r_mode == stkw_pkg::MODE_NUM) begin
                    n_halted = 1'b1;
                end else begin
                    n_mode     = stkw_pkg::MODE_NONE;
                    n_start    = '0;
                    n_pos      = '0;
                    n_class_ok = 1'b0;
                    n_val_ok   = 1'b0;
                    n_len      = '0;
                end
            end else begin
                case (r_mode)
                    stkw_pkg::MODE_PLUS: begin
                        n_mode = stkw_pkg::MODE_NONE;
                        if (r_in_char == stkw_pkg::CH_PLUS) begin
                            n_pos = w_pos1;
                        end
                    end
                    stkw_pkg::MODE_BANG: begin
                        n_mode = stkw_pkg::MODE_NONE;
                        if (r_in_char == stkw_pkg::CH_EQ) begin
                            n_pos = w_pos1;
                        end else begin
                            n_halted = 1'b1;
                        end
                    end
                    stkw_pkg::MODE_NUM: begin
                        if (w_digit) begin
                            n_pos = w_pos1;
                        end else begin
                            n_mode = stkw_pkg::MODE_NONE;
                            if (!w_space) begin
                                n_halted = 1'b1;
                            end
                        end
                    end
                    stkw_pkg::MODE_IDENT: begin
                        if (w_body) begin
                            n_class_ok = r_class_ok && r_len < stkw_pkg::CLASS_LEN
                                      && r_in_char == stkw_pkg::class_char(r_len);
                            n_val_ok   = r_val_ok && r_len < stkw_pkg::VAL_LEN
                                      && r_in_char == stkw_pkg::val_char(r_len);
                            n_len      = (r_len == stkw_pkg::LEN_MAX) ? r_len : r_len + 3'd1;
                            n_pos      = w_pos1;
                        end else begin
                            n_mode = stkw_pkg::MODE_NONE;
                        end
                    end
                    default: begin
                        n_mode = stkw_pkg::MODE_NONE;
                    end
                endcase
                if (w_fresh) begin
                    if (w_single || w_space) begin
                        n_pos = w_pos1;
                    end else if (w_start_ch) begin
                        n_start = r_pos;
                        n_pos   = w_pos1;
                        if (r_in_char == stkw_pkg::CH_PLUS) begin
                            n_mode = stkw_pkg::MODE_PLUS;
                        end else if (r_in_char == stkw_pkg::CH_BANG) begin
                            n_mode = stkw_pkg::MODE_BANG;
                        end else if (w_digit) begin
                            n_mode = stkw_pkg::MODE_NUM;
                        end else begin
                            n_mode     = stkw_pkg::MODE_IDENT;
                            n_class_ok = r_in_char == stkw_pkg::class_char(3'd0);
                            n_val_ok   = r_in_char == stkw_pkg::val_char(3'd0);
                            n_len      = 3'd1;
                        end
                    end else begin
                        n_halted = 1'b1;
                    end
                end
            end
        end
    end

    // tokens produced by this request
    always_comb begin
        stkw_pkg::t_token fresh_tok;
        logic             fresh_hit;
        w_res0    = stkw_pkg::mk_tok(stkw_pkg::K_EOF, r_pos, r_pos);
        w_res1    = stkw_pkg::mk_tok(stkw_pkg::K_EOF, r_pos, r_pos);
        w_nres    = 2'd0;
        fresh_tok = stkw_pkg::mk_tok(stkw_pkg::K_ERR, r_pos, w_pos1);
        fresh_hit = 1'b0;
        if (!r_halted) begin
            if (r_in_cmd) begin
                if (r_mode == stkw_pkg::MODE_BANG || r_mode == stkw_pkg::MODE_NUM) begin
                    w_res0 = stkw_pkg::mk_tok(stkw_pkg::K_ERR, r_start, r_pos);
                    w_nres = 2'd1;
                end else if (r_mode == stkw_pkg::MODE_PLUS) begin
                    w_res0 = stkw_pkg::mk_tok(stkw_pkg::K_PLUS, r_start, r_pos);
                    w_nres = 2'd2;
                end else if (r_mode == stkw_pkg::MODE_IDENT) begin
                    w_res0 = stkw_pkg::mk_tok(stkw_pkg::ident_kind(r_class_ok, r_val_ok, r_len),
                                              r_start, r_pos);
                    w_nres = 2'd2;
                end else begin
                    w_nres = 2'd1;
                end
            end else begin
                case (r_mode)
                    stkw_pkg::MODE_PLUS: begin
                        w_nres = 2'd1;
                        if (r_in_char == stkw_pkg::CH_PLUS) begin
                            w_res0 = stkw_pkg::mk_tok(stkw_pkg::K_PLUSPLUS, r_start, w_pos1);
                        end else begin
                            w_res0 = stkw_pkg::mk_tok(stkw_pkg::K_PLUS, r_start, r_pos);
                        end
                    end
                    stkw_pkg::MODE_BANG: begin
                        w_nres = 2'd1;
                        if (r_in_char == stkw_pkg::CH_EQ) begin
                            w_res0 = stkw_pkg::mk_tok(stkw_pkg::K_NEQ, r_start, w_pos1);
                        end else begin
                            w_res0 = stkw_pkg::mk_tok(stkw_pkg::K_ERR, r_start, r_pos);
                        end
                    end
                    stkw_pkg::MODE_NUM: begin
                        if (!w_digit) begin
                            w_nres = 2'd1;
                            w_res0 = stkw_pkg::mk_tok(w_space ? stkw_pkg::K_NUM : stkw_pkg::K_ERR,
                                                      r_start, r_pos);
                        end
                    end
                    stkw_pkg::MODE_IDENT: begin
                        if (!w_body) begin
                            w_nres = 2'd1;
                            w_res0 = stkw_pkg::mk_tok(
                                stkw_pkg::ident_kind(r_class_ok, r_val_ok, r_len), r_start, r_pos);
                        end
                    end
                    default: begin
                        w_nres = 2'd0;
                    end
                endcase
                if (w_fresh) begin
                    if (w_single) begin
                        fresh_tok = stkw_pkg::mk_tok(stkw_pkg::single_kind(r_in_char),
                                                     r_pos, w_pos1);
                        fresh_hit = 1'b1;
                    end else if (!w_space && !w_start_ch) begin
                        fresh_hit = 1'b1;
                    end
                end
                if (fresh_hit) begin
                    if (w_nres == 2'd0) begin
                        w_res0 = fresh_tok;
                        w_nres = 2'd1;
                    end else begin
                        w_res1 = fresh_tok;
                        w_nres = 2'd2;
                    end
                end
            end
        end
        if (w_nres == 2'd1) begin
            w_res0.last = 1'b1;
        end
        if (w_nres == 2'd2) begin
            w_res1.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= stkw_pkg::MODE_NONE;
            r_start    <= '0;
            r_pos      <= '0;
            r_class_ok <= 1'b0;
            r_val_ok   <= 1'b0;
            r_len      <= '0;
            r_halted   <= 1'b0;
            r_wr       <= '0;
            r_rd       <= '0;
            r_count    <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (w_consume) begin
                r_in_valid <= 1'b0;
            end
            if (w_consume) begin
                r_mode     <= n_mode;
                r_start    <= n_start;
                r_pos      <= n_pos;
                r_class_ok <= n_class_ok;
                r_val_ok   <= n_val_ok;
                r_len      <= n_len;
                r_halted   <= n_halted;
            end
            r_wr    <= r_wr + stkw_pkg::t_fptr'(w_push);
            r_rd    <= r_rd + stkw_pkg::t_fptr'(w_pop);
            r_count <= r_count + stkw_pkg::t_fcnt'(w_push) - stkw_pkg::t_fcnt'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd  <= s_axis_tuser;
            r_in_char <= s_axis_tdata;
        end
    end

    // token queue
    always_ff @(posedge i_clk) begin
        if (w_push != 2'd0) begin
            r_fifo[r_wr] <= w_res0;
        end
        if (w_push == 2'd2) begin
            r_fifo[r_wr + stkw_pkg::t_fptr'(1)] <= w_res1;
        end
    end

    assign m_axis_tvalid = r_count != '0;
    assign m_axis_tdata  = {r_fifo[r_rd].end_pos, r_fifo[r_rd].start_pos};
    assign m_axis_tuser  = r_fifo[r_rd].kind;
    assign m_axis_tlast  = r_fifo[r_rd].last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= stkw_pkg::t_fcnt'(stkw_pkg::FIFO_DEPTH))
        else $error("token queue overflow");

    a_room_on_consume: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_consume |-> (r_count + stkw_pkg::t_fcnt'(w_push) - stkw_pkg::t_fcnt'(w_pop))
            <= stkw_pkg::t_fcnt'(stkw_pkg::FIFO_DEPTH))
        else $error("request consumed without queue room");

    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt cleared without reset");

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> w_push == 2'd0)
        else $error("token pushed while halted");

    a_eof_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_consume && !r_halted && r_in_cmd && r_mode != stkw_pkg::MODE_BANG
            && r_mode != stkw_pkg::MODE_NUM) |=> (r_pos == '0 && r_mode == stkw_pkg::MODE_NONE))
        else $error("end of source did not restart position");

    a_ident_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == stkw_pkg::MODE_IDENT |-> r_len != '0)
        else $error("open identifier with zero length");

endmodule

>>> dv/source_tokenizer_with_keywords_tb.sv
`timescale 1ns / 1ps

module source_tokenizer_with_keywords_tb;
    import stkw_pkg::*;

    localparam int STALL_LIMIT = 400;
    localparam int TAIL_QUIET  = 80;
    localparam int DRAIN       = 20;
    localparam int RANDOM_ROWS = 740;

    localparam logic [39:0] KW_CLASS = "class";
    localparam logic [23:0] KW_VAL   = "val";

    typedef struct {
        t_kind    kind;
        t_out_pos start_pos;
        t_out_pos end_pos;
        logic     last;
    } lex_tok_t;

    // n_typed < 0: tokens come from the lexer model, else the typed ones
    typedef struct {
        logic       cmd;
        logic [7:0] ch;
        int         n_typed;
        lex_tok_t   typed;
    } src_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // char_byte
    logic        s_axis_tuser = 1'b0;    // command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;           // start_pos, end_pos
    logic [3:0]  m_axis_tuser;           // token_kind
    logic        m_axis_tlast;           // last_of_run

    source_tokenizer_with_keywords dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    src_row_t rows[$];
    lex_tok_t tokens_due[$];
    lex_tok_t step_toks[$];
    string    near_words[$] = '{"class", "val", "clas", "classs", "va", "vall", "Class",
                                "vAl", "cval", "classval", "valclass", "_val"};

    src_row_t held;
    int       next_row = 0;
    int       items_left = 0;
    int       src_gap = 0;
    int       snk_gap = 0;
    int       src_idle_pct = 0;
    int       snk_idle_pct = 0;
    int       stall_cycles = 0;
    int       mismatches = 0;
    logic     quiet;

    // lexer model state
    t_mode lx_mode = MODE_NONE;
    t_pos  lx_start = '0;
    t_pos  lx_pos = '0;
    logic  lx_class_ok = 1'b0;
    logic  lx_val_ok = 1'b0;
    t_len  lx_len = '0;
    logic  lx_halt = 1'b0;

    function automatic logic is_ws(logic [7:0] c);
        return (c >= 8'h09 && c <= 8'h0D) || c == CH_SPACE;
    endfunction

    function automatic logic is_dec(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_word_start(logic [7:0] c);
        logic [7:0] lc;
        lc = c | 8'h20;
        return (lc >= 8'h61 && lc <= 8'h7A) || c == CH_UNDER;
    endfunction

    function automatic logic is_punct(logic [7:0] c);
        return c == CH_NL || c == CH_LBRACE || c == CH_RBRACE || c == CH_LPAR
            || c == CH_RPAR || c == CH_COLON || c == CH_EQ;
    endfunction

    function automatic logic is_known(logic [7:0] c);
        return is_punct(c) || is_ws(c) || c == CH_PLUS || c == CH_BANG || is_dec(c)
            || is_word_start(c);
    endfunction

    function automatic void lex_clear();
        lx_mode = MODE_NONE;
        lx_start = '0;
        lx_pos = '0;
        lx_class_ok = 1'b0;
        lx_val_ok = 1'b0;
        lx_len = '0;
        lx_halt = 1'b0;
    endfunction

    function automatic void lex_emit(t_kind k, t_out_pos s, t_out_pos e);
        lex_tok_t t;
        t.kind = k;
        t.start_pos = s;
        t.end_pos = e;
        t.last = 1'b0;
        step_toks = {step_toks, t};
    endfunction

    function automatic void lex_seal();
        if (step_toks.size() > 0) begin
            step_toks[step_toks.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic void word_add(logic [7:0] c);
        int n;
        n = int'(lx_len);
        lx_class_ok = lx_class_ok && (n < 5) ? (c == KW_CLASS[8 * (4 - n) +: 8]) : 1'b0;
        lx_val_ok = lx_val_ok && (n < 3) ? (c == KW_VAL[8 * (2 - n) +: 8]) : 1'b0;
        if (lx_len < LEN_MAX) begin
            lx_len = lx_len + 1'b1;
        end
    endfunction

    function automatic t_kind word_kind();
        if (lx_class_ok && lx_len == CLASS_LEN) begin
            return K_CLASS;
        end
        if (lx_val_ok && lx_len == VAL_LEN) begin
            return K_VAL;
        end
        return K_IDENT;
    endfunction

    // tokens caused by one request go to step_toks
    function automatic void lex_step(logic cmd, logic [7:0] c);
        t_kind one;
        logic  is_one;
        one = K_ERR;
        is_one = 1'b1;
        step_toks.delete();
        if (lx_halt) begin
            return;
        end
        if (cmd) begin
            if (lx_mode == MODE_BANG || lx_mode == MODE_NUM) begin
                lex_emit(K_ERR, lx_start, lx_pos);
                lx_halt = 1'b1;
            end else begin
                if (lx_mode == MODE_PLUS) begin
                    lex_emit(K_PLUS, lx_start, lx_pos);
                end else if (lx_mode == MODE_IDENT) begin
                    lex_emit(word_kind(), lx_start, lx_pos);
                end
                lex_emit(K_EOF, lx_pos, lx_pos);
                lex_clear();
            end
            lex_seal();
            return;
        end
        case (lx_mode)
            MODE_PLUS: begin
                lx_mode = MODE_NONE;
                if (c == CH_PLUS) begin
                    lx_pos = lx_pos + 1'b1;
                    lex_emit(K_PLUSPLUS, lx_start, lx_pos);
                    lex_seal();
                    return;
                end
                lex_emit(K_PLUS, lx_start, lx_pos);
            end
            MODE_BANG: begin
                lx_mode = MODE_NONE;
                if (c == CH_EQ) begin
                    lx_pos = lx_pos + 1'b1;
                    lex_emit(K_NEQ, lx_start, lx_pos);
                end else begin
                    lex_emit(K_ERR, lx_start, lx_pos);
                    lx_halt = 1'b1;
                end
                lex_seal();
                return;
            end
            MODE_NUM: begin
                if (is_dec(c)) begin
                    lx_pos = lx_pos + 1'b1;
                    return;
                end
                lx_mode = MODE_NONE;
                if (!is_ws(c)) begin
                    lex_emit(K_ERR, lx_start, lx_pos);
                    lx_halt = 1'b1;
                    lex_seal();
                    return;
                end
                lex_emit(K_NUM, lx_start, lx_pos);
            end
            MODE_IDENT: begin
                if (is_word_start(c) || is_dec(c)) begin
                    word_add(c);
                    lx_pos = lx_pos + 1'b1;
                    return;
                end
                lx_mode = MODE_NONE;
                lex_emit(word_kind(), lx_start, lx_pos);
            end
            default: begin
                lx_mode = MODE_NONE;
            end
        endcase
        case (c)
            CH_NL:     one = K_NL;
            CH_LBRACE: one = K_LBRACE;
            CH_RBRACE: one = K_RBRACE;
            CH_LPAR:   one = K_LPAR;
            CH_RPAR:   one = K_RPAR;
            CH_COLON:  one = K_COLON;
            CH_EQ:     one = K_EQ;
            default:   is_one = 1'b0;
        endcase
        if (is_one) begin
            lex_emit(one, lx_pos, lx_pos + 1'b1);
            lx_pos = lx_pos + 1'b1;
        end else if (is_ws(c)) begin
            lx_pos = lx_pos + 1'b1;
        end else if (c == CH_PLUS || c == CH_BANG || is_dec(c) || is_word_start(c)) begin
            lx_start = lx_pos;
            if (c == CH_PLUS) begin
                lx_mode = MODE_PLUS;
            end else if (c == CH_BANG) begin
                lx_mode = MODE_BANG;
            end else if (is_dec(c)) begin
                lx_mode = MODE_NUM;
            end else begin
                lx_mode = MODE_IDENT;
                lx_class_ok = 1'b1;
                lx_val_ok = 1'b1;
                lx_len = '0;
                word_add(c);
            end
            lx_pos = lx_pos + 1'b1;
        end else begin
            lex_emit(K_ERR, lx_pos, lx_pos + 1'b1);
            lx_halt = 1'b1;
        end
        lex_seal();
    endfunction

    function automatic void put(logic cmd, logic [7:0] c);
        src_row_t r;
        r.cmd = cmd;
        r.ch = c;
        r.n_typed = -1;
        r.typed = '{K_EOF, '0, '0, 1'b0};
        rows = {rows, r};
    endfunction

    function automatic void put_typed(logic cmd, logic [7:0] c, int n, t_kind k,
                                      t_out_pos s, t_out_pos e);
        src_row_t r;
        r.cmd = cmd;
        r.ch = c;
        r.n_typed = n;
        r.typed = '{k, s, e, 1'b1};
        rows = {rows, r};
    endfunction

    function automatic logic [7:0] rand_ws();
        int r;
        r = $urandom_range(0, 5);
        return (r < 5) ? 8'(8'h09 + r) : CH_SPACE;
    endfunction

    function automatic logic [7:0] rand_word_char(logic body);
        int r;
        r = $urandom_range(0, body ? 62 : 52);
        if (r < 26) begin
            return 8'(8'h41 + r);
        end else if (r < 52) begin
            return 8'(8'h61 + r - 26);
        end else if (r == 52) begin
            return CH_UNDER;
        end
        return 8'(8'h30 + r - 53);
    endfunction

    function automatic void add_src_token();
        int         r;
        int         n;
        logic [7:0] c;
        string      w;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            case ($urandom_range(0, 6))
                0:       c = CH_NL;
                1:       c = CH_LBRACE;
                2:       c = CH_RBRACE;
                3:       c = CH_LPAR;
                4:       c = CH_RPAR;
                5:       c = CH_COLON;
                default: c = CH_EQ;
            endcase
            put(1'b0, c);
        end else if (r < 30) begin
            put(1'b0, rand_ws());
        end else if (r < 40) begin
            put(1'b0, CH_PLUS);
            if ($urandom_range(0, 1) == 1) begin
                put(1'b0, CH_PLUS);
            end
        end else if (r < 45) begin
            put(1'b0, CH_BANG);
            put(1'b0, CH_EQ);
        end else if (r < 60) begin
            n = $urandom_range(1, 5);
            repeat (n) put(1'b0, 8'(8'h30 + $urandom_range(0, 9)));
            put(1'b0, rand_ws());
        end else if (r < 80) begin
            put(1'b0, rand_word_char(1'b0));
            n = $urandom_range(0, 8);
            repeat (n) put(1'b0, rand_word_char(1'b1));
        end else if (r < 92) begin
            w = near_words[$urandom_range(0, near_words.size() - 1)];
            for (int i = 0; i < w.len(); i++) begin
                put(1'b0, w[i]);
            end
        end else if (r < 96) begin
            put(1'b1, 8'($urandom_range(0, 255)));
        end else begin
            // any legal byte that cannot start a bad number or a lone bang
            do begin
                c = 8'($urandom_range(0, 255));
            end while (!is_known(c) || is_dec(c) || c == CH_BANG);
            put(1'b0, c);
        end
    endfunction

    // one error ends the source for good, so it closes the run
    function automatic void add_error_tail();
        logic [7:0] c;
        put(1'b0, CH_SPACE);
        case ($urandom_range(0, 4))
            0: begin
                put(1'b0, CH_BANG);
                do begin
                    c = 8'($urandom_range(0, 255));
                end while (c == CH_EQ);
                put(1'b0, c);
            end
            1: begin
                put(1'b0, CH_BANG);
                put(1'b1, 8'($urandom_range(0, 255)));
            end
            2: begin
                repeat ($urandom_range(1, 4)) put(1'b0, 8'(8'h30 + $urandom_range(0, 9)));
                do begin
                    c = 8'($urandom_range(0, 255));
                end while (is_ws(c) || is_dec(c));
                put(1'b0, c);
            end
            3: begin
                repeat ($urandom_range(1, 4)) put(1'b0, 8'(8'h30 + $urandom_range(0, 9)));
                put(1'b1, 8'($urandom_range(0, 255)));
            end
            default: begin
                do begin
                    c = 8'($urandom_range(0, 255));
                end while (is_known(c));
                put(1'b0, c);
            end
        endcase
        repeat (6) put(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 35;
        endcase
    endfunction

    task automatic report(string msg);
        mismatches++;
        if (mismatches <= 40) begin
            $display("mismatch: %s", msg);
        end
    endtask

    task automatic check_token();
        lex_tok_t want;
        if (tokens_due.size() == 0) begin
            report($sformatf("token kind %0d with none due", m_axis_tuser));
            return;
        end
        want = tokens_due.pop_front();
        if (m_axis_tuser !== want.kind) begin
            report($sformatf("kind got %0d want %0d", m_axis_tuser, want.kind));
        end
        if (m_axis_tdata[31:0] !== want.start_pos) begin
            report($sformatf("start_pos got %0d want %0d", m_axis_tdata[31:0], want.start_pos));
        end
        if (m_axis_tdata[63:32] !== want.end_pos) begin
            report($sformatf("end_pos got %0d want %0d", m_axis_tdata[63:32], want.end_pos));
        end
        if (m_axis_tlast !== want.last) begin
            report($sformatf("last got %0b want %0b", m_axis_tlast, want.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                lex_step(held.cmd, held.ch);
                if (held.n_typed < 0) begin
                    foreach (step_toks[k]) tokens_due = {tokens_due, step_toks[k]};
                end else if (held.n_typed == 1) begin
                    tokens_due = {tokens_due, held.typed};
                end
                items_left--;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                check_token();
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            quiet = (rows.size() - next_row) < TAIL_QUIET;

            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    src_gap--;
                end else if (next_row < rows.size()) begin
                    if (next_row % 50 == 0) begin
                        src_idle_pct = pick_idle_pct();
                        snk_idle_pct = pick_idle_pct();
                    end
                    held = rows[next_row];
                    next_row++;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= held.ch;
                    s_axis_tuser <= held.cmd;
                    if (!quiet && $urandom_range(0, 99) < src_idle_pct) begin
                        src_gap = $urandom_range(1, 19);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end

            if (snk_gap > 0) begin
                m_axis_tready <= 1'b0;
                snk_gap--;
            end else begin
                m_axis_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 99) < snk_idle_pct) begin
                    snk_gap = $urandom_range(1, 19);
                end
            end
        end
    end

    initial begin
        // punctuation, whitespace extremes, two-byte operators
        put_typed(1'b0, CH_LBRACE, 1, K_LBRACE, 0, 1);
        put_typed(1'b0, CH_RBRACE, 1, K_RBRACE, 1, 2);
        put_typed(1'b0, CH_LPAR, 1, K_LPAR, 2, 3);
        put_typed(1'b0, CH_RPAR, 1, K_RPAR, 3, 4);
        put_typed(1'b0, CH_COLON, 1, K_COLON, 4, 5);
        put_typed(1'b0, CH_EQ, 1, K_EQ, 5, 6);
        put_typed(1'b0, CH_NL, 1, K_NL, 6, 7);
        put_typed(1'b0, 8'h09, 0, K_EOF, 0, 0);
        put_typed(1'b0, CH_SPACE, 0, K_EOF, 0, 0);
        put_typed(1'b0, CH_BANG, 0, K_EOF, 0, 0);
        put_typed(1'b0, CH_EQ, 1, K_NEQ, 9, 11);
        put_typed(1'b0, CH_PLUS, 0, K_EOF, 0, 0);
        put_typed(1'b0, CH_PLUS, 1, K_PLUSPLUS, 11, 13);
        // lone plus closed by an identifier, keyword closed by a paren
        put(1'b0, CH_PLUS);
        put(1'b0, "c");
        put(1'b0, "l");
        put(1'b0, "a");
        put(1'b0, "s");
        put(1'b0, "s");
        put(1'b0, CH_LPAR);
        put(1'b0, "0");
        put(1'b0, "9");
        put(1'b0, 8'h0D);
        // keyword flushed by end of source, then an empty source
        put(1'b0, "v");
        put(1'b0, "a");
        put(1'b0, "l");
        put(1'b1, 8'hFF);
        put_typed(1'b1, 8'h00, 1, K_EOF, 0, 0);

        while (rows.size() < RANDOM_ROWS) begin
            add_src_token();
        end
        add_error_tail();
        items_left = rows.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (items_left > 0 || tokens_due.size() > 0) begin
            @(negedge i_clk);
            if (stall_cycles >= STALL_LIMIT) begin
                $display("source_tokenizer_with_keywords_tb NOT OK");
                $finish;
            end
        end
        repeat (DRAIN) @(negedge i_clk);
        if (mismatches == 0 && tokens_due.size() == 0) begin
            $display("source_tokenizer_with_keywords_tb OK");
        end else begin
            $display("source_tokenizer_with_keywords_tb NOT OK");
        end
        $finish;
    end

endmodule
